[hw/rtl/cte_pkg.sv]
// ----------------------------------------------------------------------------
// cte_pkg: shared types and constants for the calendar to epoch converter
// Payload structs of both channels, calendar constants, the cumulative month
// table and the leap-second instant compare.
// ----------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

  // One input word: a broken-down date and time
  typedef struct packed {
    logic [13:0] year_value;
    logic [3:0]  month_value;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_value;
    logic [5:0]  minute_value;
    logic [5:0]  second_value;
  } stamp_t;

  // One result word
  typedef struct packed {
    logic signed [38:0] epoch_seconds;
    logic               bad_month;
  } epoch_t;

  localparam int unsigned NUM_LEAPS = 5;

  localparam logic [13:0] YEAR_CAP     = 14'd9999;
  // floor(x * 5243 / 2^17) equals floor(x / 25) for every x below 2500
  localparam logic [12:0] RECIP25      = 13'd5243;
  localparam logic [3:0]  MONTH_FIRST  = 4'd1;
  localparam logic [3:0]  MONTH_MARCH  = 4'd3;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;
  // days in years 1..1969
  localparam logic [23:0] DAYS_TO_1970 = 24'd719162;
  // year zero is a leap year that starts 366 days before year 1
  localparam logic [23:0] YEAR0_DAYS   = 24'd0 - 24'd719528;
  localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [16:0] SECS_PER_MIN  = 17'd60;

  // Leap-second instants as packed {year, month, day, hour, minute, second};
  // every field fits its own bit width, so this order matches the decimal key order
  localparam logic [39:0] LEAP_KEYS [NUM_LEAPS] = '{
    {14'd2006, 4'd1, 5'd1, 5'd8, 6'd59, 6'd59},
    {14'd2009, 4'd1, 5'd1, 5'd8, 6'd59, 6'd59},
    {14'd2012, 4'd7, 5'd1, 5'd8, 6'd59, 6'd59},
    {14'd2015, 4'd7, 5'd1, 5'd8, 6'd59, 6'd59},
    {14'd2017, 4'd1, 5'd1, 5'd8, 6'd59, 6'd59}
  };

  // Days in the year before the first of the given month
  function automatic logic [8:0] month_days_before(input logic [3:0] month);
    logic [8:0] days;
    case (month)
      4'd1:    days = 9'd0;
      4'd2:    days = 9'd31;
      4'd3:    days = 9'd59;
      4'd4:    days = 9'd90;
      4'd5:    days = 9'd120;
      4'd6:    days = 9'd151;
      4'd7:    days = 9'd181;
      4'd8:    days = 9'd212;
      4'd9:    days = 9'd243;
      4'd10:   days = 9'd273;
      4'd11:   days = 9'd304;
      4'd12:   days = 9'd334;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Count the leap-second instants that the key strictly passes
  function automatic logic [2:0] leaps_passed(input logic [39:0] key);
    logic [2:0] count;
    count = 3'd0;
    for (int i = 0; i < NUM_LEAPS; i++) begin
      if (key > LEAP_KEYS[i]) count = count + 3'd1;
    end
    return count;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/cte_ifs.sv]
// ----------------------------------------------------------------------------
// cte_in_if / cte_out_if: valid-ready channels of the converter
// A word moves on a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface cte_in_if;
  import cte_pkg::*;

  logic   valid;
  logic   ready;
  stamp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cte_out_if;
  import cte_pkg::*;

  logic   valid;
  logic   ready;
  epoch_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/calendar_to_epoch_seconds.sv]
// ----------------------------------------------------------------------------
// calendar_to_epoch_seconds: Gregorian date and time to epoch seconds
// Converts year..second into signed seconds since 1970-01-01, counting the
// fixed leap-second instants, in a four-register pipeline.
// ----------------------------------------------------------------------------
//  channel  dir  word     fields
//  stamp    in   stamp_t  year, month, day, hour, minute, second
//  result   out  epoch_t  epoch_seconds, bad_month
//
//  One word per cycle sustained while result.ready stays high.
//  Stages: year quotients and time of day; day count; multiply by 86400;
//  result register. The day-count multiply sets the longest path.
//  A stalled result holds its register; earlier stages keep filling bubbles.
//  Synchronous reset empties every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_to_epoch_seconds (
  input  wire logic clk,
  input  wire logic rst,
  cte_in_if.sink    stamp,
  cte_out_if.source result
);
  import cte_pkg::*;

  typedef struct packed {
    logic        year_zero;
    logic [13:0] ym1;
    logic [11:0] q4;
    logic [6:0]  q100;
    logic [4:0]  q400;
    logic        leap;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [16:0] tod;
    logic        bad;
  } s1_t;

  typedef struct packed {
    logic signed [22:0] days;
    logic [16:0]        tod;
    logic               bad;
  } s2_t;

  // pipeline registers
  stamp_t s0;
  s1_t    s1;
  s2_t    s2;
  epoch_t s3;
  logic   v0, v1, v2, v3;
  logic   en0, en1, en2, en3;

  // stage 0 logic
  logic [13:0] yc, ym1;
  logic [11:0] q4, y4;
  logic [24:0] p_q100, p_y100;
  logic [22:0] p_q400, p_y400;
  logic [39:0] key;
  logic [16:0] tod;
  s1_t         s1_next;

  // stage 1 logic
  logic [21:0] base;
  logic [23:0] days_year, days_all;

  // stage 2 logic
  logic signed [40:0] prod;

  // ---- handshake: a stage loads when empty or when it drains ----
  assign en3 = !v3 || result.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign en0 = !v0 || en1;
  assign stamp.ready  = en0;
  assign result.valid = v3;
  assign result.data  = s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en0) v0 <= stamp.valid;
      if (en1) v1 <= v0;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // ---- stage 0: cap year, quotients by 4, 100 and 400, time of day ----
  always_comb begin
    yc  = (s0.year_value > YEAR_CAP) ? YEAR_CAP : s0.year_value;
    ym1 = yc - 14'd1;
    q4  = ym1[13:2];
    y4  = yc[13:2];
    p_q100 = 25'(q4) * 25'(RECIP25);
    p_y100 = 25'(y4) * 25'(RECIP25);
    p_q400 = 23'(ym1[13:4]) * 23'(RECIP25);
    p_y400 = 23'(yc[13:4]) * 23'(RECIP25);
    key = {yc, s0.month_value, s0.day_of_month, s0.hour_value,
           s0.minute_value, s0.second_value};
    tod = 17'(s0.hour_value) * SECS_PER_HOUR + 17'(s0.minute_value) * SECS_PER_MIN
        + 17'(s0.second_value) + 17'(leaps_passed(key));

    s1_next.year_zero = (yc == 14'd0);
    s1_next.ym1       = ym1;
    s1_next.q4        = q4;
    s1_next.q100      = p_q100[23:17];
    s1_next.q400      = p_q400[21:17];
    // a century year is spotted where the quotient by 100 steps up; it is
    // a leap year only where the quotient by 400 steps up as well
    s1_next.leap      = (yc == 14'd0) ||
                        ((yc[1:0] == 2'd0) &&
                         ((p_y100[23:17] == p_q100[23:17]) ||
                          (p_y400[21:17] != p_q400[21:17])));
    s1_next.month     = s0.month_value;
    s1_next.day       = s0.day_of_month;
    s1_next.tod       = tod;
    s1_next.bad       = (s0.month_value < MONTH_FIRST) || (s0.month_value > MONTH_LAST);
  end

  // ---- stage 1: day count relative to 1970-01-01 ----
  always_comb begin
    base      = 22'(s1.ym1) * 22'd365 + 22'(s1.q4) - 22'(s1.q100) + 22'(s1.q400);
    days_year = s1.year_zero ? YEAR0_DAYS : ({2'b00, base} - DAYS_TO_1970);
    days_all  = days_year + 24'(month_days_before(s1.month))
              + 24'(s1.leap && (s1.month >= MONTH_MARCH))
              + 24'(s1.day) - 24'd1;
  end

  // ---- stage 2: seconds of the whole days ----
  assign prod = s2.days * SECS_PER_DAY;

  // advance payload registers
  always_ff @(posedge clk) begin
    if (en0) s0 <= stamp.data;
    if (en1) s1 <= s1_next;
    if (en2) begin
      s2.days <= days_all[22:0];
      s2.tod  <= s1.tod;
      s2.bad  <= s1.bad;
    end
    if (en3) begin
      s3.epoch_seconds <= s2.bad ? 39'sd0 : (prod[38:0] + 39'(s2.tod));
      s3.bad_month     <= s2.bad;
    end
  end

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.data.bad_month |-> result.data.epoch_seconds == 39'sd0)
    else $error("bad month with nonzero seconds");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !v0 |-> stamp.ready)
    else $error("empty input stage refuses a word");

  a_move_on: assert property (@(posedge clk) disable iff (rst)
    v0 && en1 |=> v1)
    else $error("word lost between stages 0 and 1");

  // day zero of January in year zero gives the lowest count
  a_days_range: assert property (@(posedge clk) disable iff (rst)
    v2 && !s2.bad |-> (s2.days >= -23'sd719529) && (s2.days <= 23'sd2932897))
    else $error("day count out of range");
`endif

endmodule

`default_nettype wire
